### design/button_debounce_long_repeat_macros.svh
// ----------------------------------------------------------------------------
// Button debouncer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_REPEAT_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_REPEAT_MACROS_SVH

// Check an implication at every rising edge outside reset.
`define BDLR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication whose consequent must hold in the following cycle.
`define BDLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bdlr_pkg.sv
// ----------------------------------------------------------------------------
// Button debouncer package
// Widths, register codes, reset values and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlr_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  // Register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] RegActiveLevel  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDebounceTime = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLongTime     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRepeatStart  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRepeatPeriod = 3'd4;

  // Reset values
  localparam logic            RstActiveLevel  = 1'b0;
  localparam logic [CfgW-1:0] RstDebounceTime = 16'd50;
  localparam logic [CfgW-1:0] RstLongTime     = 16'd800;
  localparam logic [CfgW-1:0] RstRepeatStart  = 16'd800;
  localparam logic [CfgW-1:0] RstRepeatPeriod = 16'd120;

  typedef struct packed {
    logic            down_level;
    logic [CfgW-1:0] debounce_time;
    logic [CfgW-1:0] long_time;
    logic [CfgW-1:0] repeat_start;
    logic [CfgW-1:0] repeat_period;
  } cfg_t;

  typedef struct packed {
    logic repeat_event;
    logic long_event;
    logic release_event;
    logic press_event;
    logic is_down;
  } result_t;

endpackage

`default_nettype wire

### design/bdlr_cfg_regs.sv
// ----------------------------------------------------------------------------
// Button debouncer configuration registers
// Decode writes by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlr_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [bdlr_pkg::CfgIdxW-1:0]  wr_index,
  input  wire logic [bdlr_pkg::CfgW-1:0]     wr_data,
  output bdlr_pkg::cfg_t                     cfg
);
  import bdlr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.down_level    <= RstActiveLevel;
      cfg.debounce_time <= RstDebounceTime;
      cfg.long_time     <= RstLongTime;
      cfg.repeat_start  <= RstRepeatStart;
      cfg.repeat_period <= RstRepeatPeriod;
    end else if (wr_en) begin
      case (wr_index)
        RegActiveLevel:  cfg.down_level    <= wr_data[0];
        RegDebounceTime: cfg.debounce_time <= wr_data;
        RegLongTime:     cfg.long_time     <= wr_data;
        RegRepeatStart:  cfg.repeat_start  <= wr_data;
        RegRepeatPeriod: cfg.repeat_period <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/bdlr_step.sv
// ----------------------------------------------------------------------------
// Button debouncer poll step
// Button state registers and the one-poll update, applied when fire is high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_debounce_long_repeat_macros.svh"

module bdlr_step (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         fire,
  input  wire logic                         pin_level,
  input  wire logic [bdlr_pkg::TimeW-1:0]   now_time,
  input  bdlr_pkg::cfg_t                    cfg,
  output bdlr_pkg::result_t                 res
);
  import bdlr_pkg::*;

  logic             raw_pressed;
  logic             stable_pressed;
  logic             long_done;
  logic [TimeW-1:0] raw_change_time;
  logic [TimeW-1:0] press_time;
  logic [TimeW-1:0] last_repeat_time;

  logic             pressed;
  logic             changed;
  logic             confirm;
  logic             stable_pressed_next;
  logic             long_done_base;
  logic             long_done_next;
  logic [TimeW-1:0] since_change;
  logic [TimeW-1:0] held;
  logic [TimeW-1:0] since_repeat;

  always_comb begin
    pressed = (pin_level == cfg.down_level);
    changed = (pressed != raw_pressed);
    // a fresh change restarts the debounce window at this poll
    since_change = changed ? '0 : (now_time - raw_change_time);
    confirm = (stable_pressed != pressed) &&
              (since_change >= {{(TimeW-CfgW){1'b0}}, cfg.debounce_time});
    stable_pressed_next = confirm ? pressed : stable_pressed;

    res.is_down       = stable_pressed_next;
    res.press_event   = confirm && pressed;
    res.release_event = confirm && !pressed;

    // a confirmed press restarts hold and repeat timing at this poll
    held           = res.press_event ? '0 : (now_time - press_time);
    since_repeat   = res.press_event ? '0 : (now_time - last_repeat_time);
    long_done_base = res.press_event ? 1'b0 : long_done;

    res.long_event = stable_pressed_next && !long_done_base &&
                     (held >= {{(TimeW-CfgW){1'b0}}, cfg.long_time});
    res.repeat_event = stable_pressed_next && (cfg.repeat_period != '0) &&
                       (held >= {{(TimeW-CfgW){1'b0}}, cfg.repeat_start}) &&
                       (since_repeat >= {{(TimeW-CfgW){1'b0}}, cfg.repeat_period});
    long_done_next = long_done_base || res.long_event;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_pressed    <= 1'b0;
      stable_pressed <= 1'b0;
      long_done      <= 1'b0;
    end else if (fire) begin
      raw_pressed    <= pressed;
      stable_pressed <= stable_pressed_next;
      long_done      <= long_done_next;
    end
  end

  // time stamps are always written before they are read
  always_ff @(posedge clk) begin
    if (fire && changed) begin
      raw_change_time <= now_time;
    end
    if (fire && res.press_event) begin
      press_time <= now_time;
    end
    if (fire && (res.press_event || res.repeat_event)) begin
      last_repeat_time <= now_time;
    end
  end

  `BDLR_ASSERT_IMPL(a_press_excl, res.press_event, !res.release_event, "press with release")
  `BDLR_ASSERT_IMPL(a_release_up, res.release_event, !res.is_down, "release while down")
  `BDLR_ASSERT_IMPL(a_no_repeat_on_press, res.press_event, !res.repeat_event, "repeat on press")
  `BDLR_ASSERT_NEXT(a_long_once, fire && res.long_event, long_done, "long flag not held")
  `BDLR_ASSERT_IMPL(a_long_down, res.long_event || res.repeat_event, res.is_down, "hold event up")

endmodule

`default_nettype wire

### design/button_debounce_long_repeat.sv
// ----------------------------------------------------------------------------
// Button debouncer with long press and auto-repeat
// Debounces polled pin samples and raises press, release, long and repeat events.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one poll per transfer on the s_axis channel: the raw pin level and a
//   free-running millisecond timestamp. Every poll yields exactly one result
//   on the m_axis channel: the debounced state and four one-poll event bits.
//   An accepted poll waits in the input register, then the update logic
//   loads its result into the result register, from which it transfers.
//   Throughput is one poll per clock while the receiver keeps up; the only
//   path between registers is three 32-bit subtractions with their compares.
//   When the receiver stalls, the result register holds and the input
//   register still takes one poll; after that s_axis_tready drops until the
//   result drains. Button state advances only as a poll moves into the result
//   register, so no poll is lost or repeated.
//   Reset (rst, synchronous) releases the button, clears both stages and loads
//   the default thresholds. Write thresholds on the cfg channel only while no
//   poll is in flight; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_long_repeat (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // slave side: [0] pin_level, [32:1] now_time, [39:33] zero
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [bdlr_pkg::InDataW-1:0]     s_axis_tdata,
  // master side: [0] is_down, [1] press_event, [2] release_event,
  // [3] long_event, [4] repeat_event, [7:5] zero
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [bdlr_pkg::OutDataW-1:0]         m_axis_tdata,
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bdlr_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [bdlr_pkg::CfgW-1:0]        cfg_data
);
  import bdlr_pkg::*;

  cfg_t             cfg;
  result_t          step_res;
  result_t          out_res;

  logic             in_valid;
  logic             in_pin_level;
  logic [TimeW-1:0] in_now_time;
  logic             advance;
  logic             take;

  assign cfg_ready = 1'b1;

  bdlr_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // move the held poll into the result stage when that stage is free or draining
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_pin_level <= s_axis_tdata[0];
      in_now_time  <= s_axis_tdata[TimeW:1];
    end
  end

  bdlr_step u_step (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .pin_level (in_pin_level),
    .now_time  (in_now_time),
    .cfg       (cfg),
    .res       (step_res)
  );

  // result register: load on advance, drop once the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tdata = {{(OutDataW-$bits(result_t)){1'b0}}, out_res};

endmodule

`default_nettype wire

### dv/bdlr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button debouncer checker
// Watches the poll, result and register channels, keeps its own model of the
// debouncer state and compares each result transfer with the oldest forecast.
// ----------------------------------------------------------------------------

module bdlr_checker
  import bdlr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_data,
  output int                  fail_count,
  output int                  pending
);

  cfg_t             thresholds;
  logic             raw_down;
  logic             stable_down;
  logic             long_fired;
  logic [TimeW-1:0] raw_edge_ms;
  logic [TimeW-1:0] hold_start_ms;
  logic [TimeW-1:0] last_repeat_ms;
  result_t          expected_events[$];
  int               results_seen;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, results_seen, msg);
    fail_count++;
  endtask

  // Advance the debouncer by one poll and return the event word it yields.
  function automatic result_t debounce_poll(input logic pin, input logic [TimeW-1:0] now_ms);
    result_t          ev;
    logic             pressed;
    logic [TimeW-1:0] since_edge;
    logic [TimeW-1:0] held;
    logic [TimeW-1:0] since_repeat;
    ev = '0;
    pressed = (pin == thresholds.down_level);
    if (pressed != raw_down) begin
      raw_down    = pressed;
      raw_edge_ms = now_ms;
    end
    since_edge = now_ms - raw_edge_ms;
    if (stable_down != raw_down && since_edge >= thresholds.debounce_time) begin
      stable_down = raw_down;
      if (stable_down) begin
        ev.press_event = 1'b1;
        hold_start_ms  = now_ms;
        last_repeat_ms = now_ms;
        long_fired     = 1'b0;
      end else begin
        ev.release_event = 1'b1;
      end
    end
    if (stable_down) begin
      held         = now_ms - hold_start_ms;
      since_repeat = now_ms - last_repeat_ms;
      if (!long_fired && held >= thresholds.long_time) begin
        ev.long_event = 1'b1;
        long_fired    = 1'b1;
      end
      if (thresholds.repeat_period != '0 && held >= thresholds.repeat_start &&
          since_repeat >= thresholds.repeat_period) begin
        ev.repeat_event = 1'b1;
        last_repeat_ms  = now_ms;
      end
    end
    ev.is_down = stable_down;
    return ev;
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      thresholds     = '{RstActiveLevel, RstDebounceTime, RstLongTime, RstRepeatStart,
                         RstRepeatPeriod};
      raw_down       = 1'b0;
      stable_down    = 1'b0;
      long_fired     = 1'b0;
      raw_edge_ms    = '0;
      hold_start_ms  = '0;
      last_repeat_ms = '0;
      results_seen   = 0;
      expected_events.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegActiveLevel:  thresholds.down_level    = cfg_data[0];
          RegDebounceTime: thresholds.debounce_time = cfg_data;
          RegLongTime:     thresholds.long_time     = cfg_data;
          RegRepeatStart:  thresholds.repeat_start  = cfg_data;
          RegRepeatPeriod: thresholds.repeat_period = cfg_data;
          default: ;
        endcase
      end
      // compare before queuing: a poll never produces its result on the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("result %b with no poll outstanding", got));
        end else begin
          want = expected_events.pop_front();
          if (got.is_down !== want.is_down)
            report_mismatch($sformatf("is_down got %b want %b", got.is_down, want.is_down));
          if (got.press_event !== want.press_event)
            report_mismatch($sformatf("press_event got %b want %b",
                                      got.press_event, want.press_event));
          if (got.release_event !== want.release_event)
            report_mismatch($sformatf("release_event got %b want %b",
                                      got.release_event, want.release_event));
          if (got.long_event !== want.long_event)
            report_mismatch($sformatf("long_event got %b want %b",
                                      got.long_event, want.long_event));
          if (got.repeat_event !== want.repeat_event)
            report_mismatch($sformatf("repeat_event got %b want %b",
                                      got.repeat_event, want.repeat_event));
        end
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_events.push_back(debounce_poll(s_axis_tdata[0], s_axis_tdata[TimeW:1]));
      pending <= expected_events.size();
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button debouncer testbench
// Drives polls shaped as button presses with bounce, long holds and timestamp
// wraps through several threshold settings, with random gaps on both sides.
// ----------------------------------------------------------------------------

module tb;
  import bdlr_pkg::*;

  // longest run of cycles with no transfer on any channel before giving up;
  // the deliberate receiver hold stays well below this limit
  localparam int unsigned StallLimit = 3000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgW-1:0]     cfg_data = '0;

  int                  fail_count;
  int                  pending;

  // stimulus state
  logic [TimeW-1:0]    now_ms = '0;
  logic                cur_active = RstActiveLevel;
  int unsigned         span = RstLongTime / 6 + 2;
  int unsigned         polls_sent = 0;
  int unsigned         steady_left = 0;
  bit                  src_steady = 1'b0;
  int unsigned         holds_asked = 0;
  int unsigned         holds_done = 0;
  int unsigned         idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  button_debounce_long_repeat dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),  // [0] pin_level, [32:1] now_time, [39:33] zero
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),  // [0] is_down, [1] press, [2] release, [3] long,
                                    // [4] repeat, [7:5] zero
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  bdlr_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Offer one poll at the current timestamp and hold it until the transfer.
  // Valid stays high across back-to-back polls; it only drops for a gap.
  task automatic send_poll(input logic pin);
    int unsigned gap;
    gap = (steady_left > 0 || src_steady) ? 0 : $urandom_range(0, 19);
    if (steady_left > 0) steady_left--;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - TimeW - 1){1'b0}}, now_ms, pin};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    polls_sent++;
  endtask

  task automatic poll_at(input logic [TimeW-1:0] t, input logic pin);
    now_ms = t;
    send_poll(pin);
  endtask

  // Drop valid and hold off until every poll in flight has returned.
  task automatic drain_polls();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Valid stays high across consecutive writes; the caller drops it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Load all thresholds; the active level goes in with junk in the upper bits.
  task automatic write_all(input logic act, input logic [CfgW-1:0] db,
                           input logic [CfgW-1:0] lt, input logic [CfgW-1:0] rs,
                           input logic [CfgW-1:0] rp);
    logic [CfgW-1:0] act_word;
    int unsigned     widest;
    act_word    = CfgW'($urandom);
    act_word[0] = act;
    write_reg(RegActiveLevel, act_word);
    write_reg(RegDebounceTime, db);
    write_reg(RegLongTime, lt);
    write_reg(RegRepeatStart, rs);
    write_reg(RegRepeatPeriod, rp);
    cfg_valid <= 1'b0;
    cur_active = act;
    widest = int'(db);
    if (int'(lt) > widest) widest = int'(lt);
    if (int'(rs) > widest) widest = int'(rs);
    if (int'(rp) > widest) widest = int'(rp);
    // step size so that a hold of a couple dozen polls crosses every threshold
    span = widest / 6 + 2;
  endtask

  // Mostly step forward by up to one span; now and then stall, jump or go back.
  task automatic advance_time();
    case ($urandom_range(0, 39))
      0:       now_ms = $urandom;
      1:       now_ms = now_ms - $urandom_range(1, 4000);
      2, 3:    ;
      default: now_ms = now_ms + $urandom_range(0, span);
    endcase
  endtask

  task automatic bounce();
    int unsigned n;
    n = $urandom_range(0, 4);
    repeat (n) begin
      now_ms = now_ms + $urandom_range(0, span / 8);
      send_poll(1'($urandom_range(0, 1)));
    end
  endtask

  // One button cycle: bounce down, hold, bounce up, rest released.
  task automatic press_cycle();
    int unsigned n;
    bounce();
    n = $urandom_range(1, 24);
    repeat (n) begin
      advance_time();
      send_poll(cur_active);
    end
    bounce();
    n = $urandom_range(1, 8);
    repeat (n) begin
      advance_time();
      send_poll(!cur_active);
    end
  endtask

  task automatic noise_burst();
    int unsigned n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) now_ms = $urandom;
      else advance_time();
      send_poll(1'($urandom_range(0, 1)));
    end
  endtask

  // Random traffic under one setting, with one receiver hold-off while the
  // sender keeps pushing and one full drain somewhere in the middle.
  task automatic run_phase(input int unsigned count);
    int unsigned stop_at;
    int unsigned hold_at;
    int unsigned pause_at;
    bit          hold_sent;
    bit          paused;
    stop_at   = polls_sent + count;
    hold_at   = polls_sent + $urandom_range(10, count / 2);
    pause_at  = polls_sent + $urandom_range(count / 2, count - 10);
    hold_sent = 1'b0;
    paused    = 1'b0;
    while (polls_sent < stop_at) begin
      src_steady = ($urandom_range(0, 3) == 0);
      if (!hold_sent && polls_sent >= hold_at) begin
        holds_asked++;
        steady_left = 40;
        hold_sent   = 1'b1;
      end
      if (!paused && polls_sent >= pause_at) begin
        drain_polls();
        paused = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) noise_burst();
      else press_cycle();
    end
    drain_polls();
  endtask

  // Receiver: a fresh stall per result, steady stretches, and long hold-offs
  // on request so the pipeline backs up into the poll channel.
  initial begin : receiver
    int unsigned gap;
    int unsigned hold_len;
    int unsigned taken;
    bit          steady;
    taken  = 0;
    steady = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holds_done != holds_asked) begin
        hold_len = $urandom_range(150, 300);
        m_axis_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        holds_done++;
      end
      if (taken % 32 == 0) steady = ($urandom_range(0, 3) == 0);
      gap = steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      taken++;
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [CfgIdxW-1:0] stray_idx;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default thresholds, pin low means pressed: bounce, press, long and
    // repeat together, repeat spacing, release after bounce.
    poll_at(32'd0, 1'b1);
    poll_at(32'd0, 1'b0);
    poll_at(32'd49, 1'b0);
    poll_at(32'd50, 1'b0);
    poll_at(32'd850, 1'b0);
    poll_at(32'd969, 1'b0);
    poll_at(32'd970, 1'b0);
    poll_at(32'd980, 1'b1);
    poll_at(32'd990, 1'b0);
    poll_at(32'd1000, 1'b1);
    poll_at(32'd1050, 1'b1);
    // press confirmed across the timestamp wrap, then a backwards step that
    // reads as a very long hold
    poll_at(32'hFFFF_FFF0, 1'b0);
    poll_at(32'h0000_0030, 1'b0);
    poll_at(32'h0000_0010, 1'b0);
    // release confirmed across the wrap
    poll_at(32'hFFFF_FFFF, 1'b1);
    poll_at(32'h0000_0000, 1'b1);
    poll_at(32'h0000_0031, 1'b1);
    run_phase(150);

    // Zero debounce and zero long time: press and long land on the same poll,
    // and a zero period keeps repeats off.
    write_all(1'b1, '0, '0, '0, '0);
    poll_at(32'd5, 1'b1);
    poll_at(32'd5, 1'b1);
    poll_at(32'd6, 1'b0);
    poll_at(32'd7, 1'b1);
    run_phase(200);

    write_all(1'b0, '1, '1, '1, '1);
    run_phase(250);

    // repeat on every millisecond of the hold
    write_all(1'b1, '0, '0, '0, 16'd1);
    run_phase(200);

    // writes to unused indexes must leave the thresholds alone
    stray_idx = CfgIdxW'(RegRepeatPeriod + $urandom_range(1, 3));
    write_reg(stray_idx, CfgW'($urandom));
    stray_idx = CfgIdxW'(RegRepeatPeriod + $urandom_range(1, 3));
    write_reg(stray_idx, CfgW'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
    run_phase(200);

    repeat (3) begin
      write_all(1'($urandom_range(0, 1)), CfgW'($urandom_range(0, 20)),
                CfgW'($urandom_range(0, 300)), CfgW'($urandom_range(0, 300)),
                CfgW'($urandom_range(0, 60)));
      run_phase(250);
    end

    write_all(1'($urandom_range(0, 1)), CfgW'($urandom_range(0, 65535)),
              CfgW'($urandom_range(0, 65535)), CfgW'($urandom_range(0, 65535)),
              CfgW'($urandom_range(0, 65535)));
    run_phase(250);

    // everything has returned; let the two-stage pipeline settle
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
